FILE: hw/rtl/rprd_pkg.sv
// ----------------------------------------------------------------------------
// rprd_pkg: shared types and constants of the RLE pixel row decoder
// Decode phases, decoder state and result records, control byte codes and
// configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package rprd_pkg;

    // Control byte codes
    localparam logic [7:0] LIT_MAX  = 8'h7F;   // highest literal run control
    localparam logic [7:0] EXT_CODE = 8'hFF;   // extended 16-bit count follows
    localparam logic [7:0] REP_BASE = 8'h80;   // repeat count offset

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT = 2'd2;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [2:0] {
        PH_CTRL,
        PH_LIT,
        PH_CNT_LO,
        PH_CNT_HI,
        PH_VALUE
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [6:0]  literal_left;
        logic [7:0]  count_low;
        logic [15:0] run_length;
        logic [16:0] column;
        logic [15:0] row;
        logic        finished;
    } dec_state_t;

    typedef struct packed {
        logic        emit;
        logic [7:0]  pixel_value;
        logic [15:0] repeat_count;
        logic        row_done;
        logic        image_done;
    } dec_result_t;

    localparam dec_state_t STATE_CLEAR = '{
        phase:        PH_CTRL,
        literal_left: 7'd0,
        count_low:    8'd0,
        run_length:   16'd0,
        column:       17'd0,
        row:          16'd0,
        finished:     1'b0
    };

endpackage

`default_nettype wire

FILE: hw/rtl/rle_pixel_row_decoder_core.sv
// Path: a byte is captured in the input register and decoded once the output
// register is free or being emptied; its pixel run goes to the output register.
// Throughput: one byte per cycle while the output register is free or drained.
// Reset (rst_n low, asynchronous): empties both stages, clears the decoder
// state and sets compressed_mode 0, image_width 1, image_height 1.
// ----------------------------------------------------------------------------
// rle_pixel_row_decoder_core: RLE pixel row decoder
// Input register, one decode step and an output register; tracks column and
// row and flags row and image end on each pixel run.
// ----------------------------------------------------------------------------
`default_nettype none

module rle_pixel_row_decoder_core
    import rprd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // configuration
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    // byte stream
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [7:0]             data_byte,
    input  wire logic                   start_of_image,
    // pixel runs
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [7:0]                  pixel_value,
    output logic [15:0]                 repeat_count,
    output logic                        row_done,
    output logic                        image_done
);

    logic        mode_reg;
    logic [15:0] width_reg;
    logic [15:0] height_reg;

    logic        in_valid_reg;
    logic        in_valid_next;
    logic [7:0]  byte_reg;
    logic        sof_reg;

    dec_state_t  state_reg;
    dec_state_t  state_next;
    dec_result_t res;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  pixel_reg;
    logic [15:0] count_reg;
    logic        row_done_reg;
    logic        image_done_reg;

    logic        advance;
    logic        in_xfer;

    // process the held byte once the output slot is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_xfer  = in_valid && in_ready;

    assign in_valid_next  = in_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? res.emit : (out_valid_reg && !out_ready);

    rprd_step u_step (
        .compressed_mode (mode_reg),
        .image_width     (width_reg),
        .image_height    (height_reg),
        .state_cur       (state_reg),
        .data_byte       (byte_reg),
        .start_of_image  (sof_reg),
        .state_next      (state_next),
        .result          (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            width_reg  <= 16'd1;
            height_reg <= 16'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE:   mode_reg   <= cfg_data[0];
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                default:    ;   // drop writes to unknown registers
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_CLEAR;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            byte_reg <= data_byte;
            sof_reg  <= start_of_image;
        end
        if (advance && res.emit)
        begin
            pixel_reg      <= res.pixel_value;
            count_reg      <= res.repeat_count;
            row_done_reg   <= res.row_done;
            image_done_reg <= res.image_done;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_value  = pixel_reg;
    assign repeat_count = count_reg;
    assign row_done     = row_done_reg;
    assign image_done   = image_done_reg;

`ifndef ASSERT_OFF
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (count_reg != 16'd0))
        else $error("pixel run with zero repeat count");

    a_image_ends_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!image_done_reg || row_done_reg))
        else $error("image end without row end");

    a_row_resets_column: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res.row_done) |=> (state_reg.column == 17'd0))
        else $error("column not cleared at row end");

    a_image_sets_finished: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res.image_done) |=> state_reg.finished)
        else $error("finished flag not set at image end");

    a_stall_holds_byte: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (in_valid_reg && out_valid_reg && !out_ready))
        else $error("input stalled without a full pipeline");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/rprd_step.sv
// ----------------------------------------------------------------------------
// rprd_step: one byte of RLE decoding
// Computes the next decoder state and the optional pixel run for one byte,
// including the row and image end check at the end of each token.
// ----------------------------------------------------------------------------
`default_nettype none

module rprd_step
    import rprd_pkg::*;
(
    input  wire logic        compressed_mode,
    input  wire logic [15:0] image_width,
    input  wire logic [15:0] image_height,
    input  wire dec_state_t  state_cur,
    input  wire logic [7:0]  data_byte,
    input  wire logic        start_of_image,
    output dec_state_t       state_next,
    output dec_result_t      result
);

    dec_state_t  s;
    dec_result_t r;
    logic        token_end;

    always_comb
    begin
        s         = start_of_image ? STATE_CLEAR : state_cur;
        r         = '0;
        token_end = 1'b0;

        if (s.finished)
        begin
            // hold everything until the next start of image
            r.emit = 1'b0;
        end
        else if (!compressed_mode)
        begin
            s.column       = s.column + 17'd1;
            r.emit         = 1'b1;
            r.pixel_value  = data_byte;
            r.repeat_count = 16'd1;
            token_end      = 1'b1;
        end
        else
        begin
            unique case (s.phase)
                PH_LIT:
                begin
                    s.column       = s.column + 17'd1;
                    s.literal_left = s.literal_left - 7'd1;
                    r.emit         = 1'b1;
                    r.pixel_value  = data_byte;
                    r.repeat_count = 16'd1;
                    if (s.literal_left == 7'd0)
                    begin
                        s.phase   = PH_CTRL;
                        token_end = 1'b1;
                    end
                end
                PH_CNT_LO:
                begin
                    s.count_low = data_byte;
                    s.phase     = PH_CNT_HI;
                end
                PH_CNT_HI:
                begin
                    s.run_length = {data_byte, s.count_low};
                    s.phase      = PH_VALUE;
                end
                PH_VALUE:
                begin
                    s.phase        = PH_CTRL;
                    s.column       = s.column + {1'b0, s.run_length};
                    r.emit         = (s.run_length != 16'd0);
                    r.pixel_value  = data_byte;
                    r.repeat_count = s.run_length;
                    token_end      = 1'b1;
                end
                default:
                begin
                    s.phase = PH_CTRL;
                    if (data_byte == EXT_CODE)
                    begin
                        s.phase = PH_CNT_LO;
                    end
                    else if (data_byte > LIT_MAX)
                    begin
                        s.run_length = {8'd0, data_byte - REP_BASE};
                        s.phase      = PH_VALUE;
                    end
                    else if (data_byte == 8'd0)
                    begin
                        // empty literal run still closes a token
                        token_end = 1'b1;
                    end
                    else
                    begin
                        s.literal_left = data_byte[6:0];
                        s.phase        = PH_LIT;
                    end
                end
            endcase
        end

        // row end check; the overrun past the width is dropped
        if (token_end && (s.column >= {1'b0, image_width}))
        begin
            s.column   = 17'd0;
            s.row      = s.row + 16'd1;
            r.row_done = 1'b1;
            if (s.row >= image_height)
            begin
                s.finished   = 1'b1;
                r.image_done = 1'b1;
            end
        end

        state_next = s;
        result     = r;
    end

endmodule

`default_nettype wire
